[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/reb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// reb_pkg
// shared types and constants of the rotary encoder front end
// ----------------------------------------------------------------------------
package reb_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 16;
  localparam int unsigned PERIOD_W        = 8;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;
  localparam int unsigned VOTE_SLOTS      = 3;
  localparam int unsigned SAMPLE_IDX_W    = $clog2(VOTE_SLOTS + 1);

  typedef enum logic [1:0] {
    TURN_IDLE  = 2'd0,
    TURN_ARMED = 2'd1,
    TURN_RIGHT = 2'd2,
    TURN_LEFT  = 2'd3
  } turn_e;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_APPLY = 1'b1
  } kind_e;

  // one request being processed this cycle
  typedef struct packed {
    logic fire;
    logic apply;
  } step_t;

endpackage
`default_nettype wire

[rtl/core/reb_turn_dec.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// reb_turn_dec
// quadrature click decoder with latched direction
// ----------------------------------------------------------------------------
module reb_turn_dec (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire reb_pkg::step_t step_i,
  input  wire logic          pin_a_i,
  input  wire logic          pin_b_i,
  output reb_pkg::turn_e     turn_cur_o,
  output reb_pkg::turn_e     turn_next_o
);

  reb_pkg::turn_e turn_q, turn_d;

  always_comb begin
    turn_d = turn_q;
    if (step_i.apply) begin
      // a held click is consumed by the apply
      if (turn_q == reb_pkg::TURN_RIGHT || turn_q == reb_pkg::TURN_LEFT) begin
        turn_d = reb_pkg::TURN_IDLE;
      end
    end else begin
      case (turn_q)
        reb_pkg::TURN_IDLE: begin
          if (!pin_a_i && !pin_b_i) turn_d = reb_pkg::TURN_ARMED;
        end
        reb_pkg::TURN_ARMED: begin
          if (!pin_a_i && pin_b_i) begin
            turn_d = reb_pkg::TURN_RIGHT;
          end else if (pin_a_i && !pin_b_i) begin
            turn_d = reb_pkg::TURN_LEFT;
          end
        end
        default: turn_d = turn_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_q <= reb_pkg::TURN_IDLE;
    end else if (step_i.fire) begin
      turn_q <= turn_d;
    end
  end

  assign turn_cur_o  = turn_q;
  assign turn_next_o = turn_d;

endmodule
`default_nettype wire

[rtl/core/reb_value_edit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// reb_value_edit
// one-step value edit with wraparound between limits
// ----------------------------------------------------------------------------
module reb_value_edit #(
  parameter int unsigned VALUE_WIDTH = reb_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic [VALUE_WIDTH-1:0] lower_i,
  input  wire logic [VALUE_WIDTH-1:0] upper_i,
  input  wire logic                   apply_i,
  input  wire reb_pkg::turn_e         turn_i,
  output logic      [VALUE_WIDTH-1:0] value_o
);

  always_comb begin
    value_o = value_i;
    if (apply_i) begin
      case (turn_i)
        reb_pkg::TURN_RIGHT: begin
          value_o = (value_i < upper_i) ? value_i + VALUE_WIDTH'(1) : lower_i;
        end
        reb_pkg::TURN_LEFT: begin
          value_o = (value_i > lower_i) ? value_i - VALUE_WIDTH'(1) : upper_i;
        end
        default: value_o = value_i;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/reb_btn_vote.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// reb_btn_vote
// periodic button sampling with three-sample majority vote
// ----------------------------------------------------------------------------
module reb_btn_vote (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [reb_pkg::PERIOD_W-1:0] cfg_wdata_i,
  input  wire reb_pkg::step_t               step_i,
  input  wire logic                         level_i,
  output logic                              pressed_next_o
);

  localparam int unsigned PW   = reb_pkg::PERIOD_W;
  localparam int unsigned IdxW = reb_pkg::SAMPLE_IDX_W;
  localparam int unsigned NS   = reb_pkg::VOTE_SLOTS;

  logic [PW-1:0]   period_q;
  logic [PW-1:0]   count_q, count_d, count_inc;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            samples_q [NS];
  logic            samples_d [NS];
  logic            pressed_q, pressed_d;
  logic            high_vote;
  logic            tick;

  assign tick      = step_i.fire && !step_i.apply;
  assign count_inc = count_q + PW'(1);
  assign high_vote = (samples_q[0] & samples_q[1]) | (samples_q[1] & samples_q[2]) |
                     (samples_q[0] & samples_q[2]);

  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    samples_d = samples_q;
    pressed_d = pressed_q;
    if (!step_i.apply) begin
      if (count_inc < period_q) begin
        count_d = count_inc;
      end else begin
        count_d = '0;
        if (idx_q < IdxW'(NS)) begin
          for (int i = 0; i < NS; i++) begin
            if (idx_q == IdxW'(i)) samples_d[i] = level_i;
          end
          idx_d = idx_q + IdxW'(1);
        end else begin
          idx_d     = '0;
          pressed_d = !high_vote;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= reb_pkg::PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      idx_q     <= '0;
      pressed_q <= 1'b0;
      for (int i = 0; i < NS; i++) samples_q[i] <= 1'b0;
    end else if (tick) begin
      count_q   <= count_d;
      idx_q     <= idx_d;
      pressed_q <= pressed_d;
      samples_q <= samples_d;
    end
  end

  assign pressed_next_o = pressed_d;

endmodule
`default_nettype wire

[rtl/core/rotary_encoder_with_button.sv]
// an accepted request is held in the input register, then moves into the result register
// throughput: one request per cycle while out_stall_i lets results drain, set by the state update loop
// the input register can take one more request while the result register waits on out_stall_i
// reset clears both valid flags, the decoder to idle, button counters and vote
// the sample period register resets to ten ticks
`default_nettype none
// ----------------------------------------------------------------------------
// rotary_encoder_with_button
// quadrature encoder click decoder, value editor and debounced button
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotary_encoder_with_button #(
  parameter int unsigned VALUE_WIDTH = reb_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [reb_pkg::PERIOD_W-1:0] cfg_wdata_i,
  // request channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         kind_i,
  input  wire logic                         pin_a_i,
  input  wire logic                         pin_b_i,
  input  wire logic                         button_pin_i,
  input  wire logic [VALUE_WIDTH-1:0]       edit_value_i,
  input  wire logic [VALUE_WIDTH-1:0]       lower_limit_i,
  input  wire logic [VALUE_WIDTH-1:0]       upper_limit_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [VALUE_WIDTH-1:0]       new_value_o,
  output logic      [1:0]                   direction_o,
  output logic                              button_pressed_o
);

  // input register stage
  logic                   s1_valid_q;
  logic                   s1_kind_q;
  logic                   s1_a_q, s1_b_q, s1_btn_q;
  logic [VALUE_WIDTH-1:0] s1_value_q, s1_lo_q, s1_hi_q;

  // result register stage
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_value_q;
  logic [1:0]             out_dir_q;
  logic                   out_pressed_q;

  logic                   in_accept;
  logic                   s1_adv;
  reb_pkg::step_t         step;
  reb_pkg::turn_e         turn_cur, turn_next;
  logic [VALUE_WIDTH-1:0] value_next;
  logic                   pressed_next;

  // the input stage moves on whenever the result register is free or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign step.fire  = s1_adv;
  assign step.apply = (s1_kind_q == reb_pkg::KIND_APPLY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !s1_adv);
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q  <= kind_i;
      s1_a_q     <= pin_a_i;
      s1_b_q     <= pin_b_i;
      s1_btn_q   <= button_pin_i;
      s1_value_q <= edit_value_i;
      s1_lo_q    <= lower_limit_i;
      s1_hi_q    <= upper_limit_i;
    end
  end

  // click decoder, holds the latched direction between requests
  reb_turn_dec u_turn (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pin_a_i     (s1_a_q),
    .pin_b_i     (s1_b_q),
    .turn_cur_o  (turn_cur),
    .turn_next_o (turn_next)
  );

  // value edit uses the direction held before this request
  reb_value_edit #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_edit (
    .value_i (s1_value_q),
    .lower_i (s1_lo_q),
    .upper_i (s1_hi_q),
    .apply_i (step.apply),
    .turn_i  (turn_cur),
    .value_o (value_next)
  );

  // button sampler, only ticks advance it
  reb_btn_vote u_btn (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .step_i         (step),
    .level_i        (s1_btn_q),
    .pressed_next_o (pressed_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s1_adv || (out_valid_q && out_stall_i);
    end
  end

  // result payload, loaded only when a request finishes
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q   <= value_next;
      out_dir_q     <= turn_next;
      out_pressed_q <= pressed_next;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign new_value_o      = out_value_q;
  assign direction_o      = out_dir_q;
  assign button_pressed_o = out_pressed_q;

  // stall toward the source only when both stages are full and the sink holds back
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o,
               s1_valid_q && out_valid_q && out_stall_i, "input stall without full pipe")

  // an apply with a held click always returns the decoder to idle
  `ASSERT_NEXT(a_apply_clears, clk_i, rst_ni,
               s1_adv && step.apply &&
               (turn_cur == reb_pkg::TURN_RIGHT || turn_cur == reb_pkg::TURN_LEFT),
               direction_o == reb_pkg::TURN_IDLE && turn_cur == reb_pkg::TURN_IDLE,
               "held click not cleared by apply")

  // a held right click survives any tick
  `ASSERT_NEXT(a_click_held, clk_i, rst_ni,
               s1_adv && !step.apply && turn_cur == reb_pkg::TURN_RIGHT,
               direction_o == reb_pkg::TURN_RIGHT, "right click lost on tick")

  // an apply never moves the button state
  `ASSERT_NEXT(a_apply_btn, clk_i, rst_ni, s1_adv && step.apply,
               button_pressed_o == $past(pressed_next), "apply changed button state")

endmodule
`default_nettype wire

[tb/sv/tb_rotary_encoder_with_button.sv]
// ----------------------------------------------------------------------------
// tb_rotary_encoder_with_button
// self-checking bench for the encoder click decoder and debounced button
//
// Requests are predicted in a small scoreboard that keeps its own decoder,
// tick counter and vote state. Every result is compared field by field with
// the oldest prediction. A directed opening covers clicks, wraps, reversed
// limits and the period corner cases. Random phases then sweep the sample
// period while both handshake sides idle at varying rates.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_with_button;
  timeunit 1ns;
  timeprecision 1ps;

  import reb_pkg::*;

  localparam int unsigned VW         = VALUE_WIDTH_DEF;
  // cycles with no handshake on either side before giving up
  localparam int unsigned STUCK_MAX  = 600;
  // receiver hold-off length for the back-pressure phase
  localparam int unsigned HOLD_LEN   = 80;
  // settle time after draining the two-stage pipe
  localparam int unsigned SETTLE     = 6;
  localparam int unsigned PRINT_MAX  = 100;

  // one request as offered on the input channel
  typedef struct packed {
    kind_e         kind;
    logic          a;
    logic          b;
    logic          btn;
    logic [VW-1:0] value;
    logic [VW-1:0] lo;
    logic [VW-1:0] hi;
  } knob_req_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic [VW-1:0] value;
    turn_e         turn;
    logic          pressed;
  } knob_res_t;

  // --------------------------------------------------------------------------
  // scoreboard: private copy of the decoder and button state, plus the queue
  // of results still owed by the block
  // --------------------------------------------------------------------------
  class knob_scoreboard;
    logic [PERIOD_W-1:0] period;
    turn_e               turn;
    logic [PERIOD_W-1:0] ticks;
    logic [1:0]          slot;
    logic [2:0]          votes;
    logic                pressed;
    knob_res_t           owed_results[$];
    int unsigned         errors;

    function new();
      period  = PERIOD_RESET;
      turn    = TURN_IDLE;
      ticks   = '0;
      slot    = '0;
      votes   = '0;
      pressed = 1'b0;
      errors  = 0;
    endfunction

    function void set_period(logic [PERIOD_W-1:0] p);
      period = p;
    endfunction

    task report(string what);
      if (errors < PRINT_MAX) $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // advance the knob model by one accepted request and queue its result
    function void note_request(knob_req_t r);
      knob_res_t           res;
      logic [PERIOD_W-1:0] nxt;
      logic [VW-1:0]       v;
      v = r.value;
      if (r.kind == KIND_TICK) begin
        case (turn)
          TURN_IDLE: begin
            if (!r.a && !r.b) turn = TURN_ARMED;
          end
          TURN_ARMED: begin
            if (!r.a && r.b) turn = TURN_RIGHT;
            else if (r.a && !r.b) turn = TURN_LEFT;
          end
          default: ;
        endcase
        nxt = ticks + 1'b1;
        if (nxt < period) begin
          ticks = nxt;
        end else begin
          ticks = '0;
          if (slot < VOTE_SLOTS) begin
            votes[slot] = r.btn;
            slot = slot + 1'b1;
          end else begin
            slot = '0;
            pressed = !((votes[0] & votes[1]) | (votes[1] & votes[2]) |
                        (votes[0] & votes[2]));
          end
        end
      end else if (turn == TURN_RIGHT) begin
        v = (r.value < r.hi) ? r.value + 1'b1 : r.lo;
        turn = TURN_IDLE;
      end else if (turn == TURN_LEFT) begin
        v = (r.value > r.lo) ? r.value - 1'b1 : r.hi;
        turn = TURN_IDLE;
      end
      res.value   = v;
      res.turn    = turn;
      res.pressed = pressed;
      owed_results.push_back(res);
    endfunction

    task check_result(knob_res_t got);
      knob_res_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result with nothing owed value=%h dir=%0d btn=%b",
                         got.value, got.turn, got.pressed));
      end else begin
        want = owed_results.pop_front();
        if (got.value !== want.value)
          report($sformatf("new_value %h, want %h", got.value, want.value));
        if (got.turn !== want.turn)
          report($sformatf("direction %0d, want %0d", got.turn, want.turn));
        if (got.pressed !== want.pressed)
          report($sformatf("button_pressed %b, want %b", got.pressed, want.pressed));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports, the inputs known from time zero
  // --------------------------------------------------------------------------
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [PERIOD_W-1:0] cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                kind_i         = 1'b0;
  logic                pin_a_i        = 1'b1;
  logic                pin_b_i        = 1'b1;
  logic                button_pin_i   = 1'b1;
  logic [VW-1:0]       edit_value_i   = '0;
  logic [VW-1:0]       lower_limit_i  = '0;
  logic [VW-1:0]       upper_limit_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [VW-1:0]       new_value_o;
  logic [1:0]          direction_o;
  logic                button_pressed_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rotary_encoder_with_button #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .pin_a_i         (pin_a_i),
    .pin_b_i         (pin_b_i),
    .button_pin_i    (button_pin_i),
    .edit_value_i    (edit_value_i),
    .lower_limit_i   (lower_limit_i),
    .upper_limit_i   (upper_limit_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .new_value_o     (new_value_o),
    .direction_o     (direction_o),
    .button_pressed_o(button_pressed_o)
  );

  knob_scoreboard sb = new();

  // idle rates in percent, changed by the phase sequencer
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // bumped by the sequencer to ask the receiver for one long hold-off
  int unsigned hold_asks = 0;

  // slowly moving button level so the vote sees both steady and bouncy input
  logic        btn_level = 1'b1;
  knob_req_t   stim_q[$];

  // --------------------------------------------------------------------------
  // receiver: checks accepted results and drives out_stall_i
  // all port reads here see the values from before the edge, since the port
  // drivers update through nonblocking assignments
  // --------------------------------------------------------------------------
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result('{new_value_o, turn_e'(direction_o), button_pressed_o});
      if (hold_asks != hold_seen) begin
        // long hold-off so the block fills and stalls its input
        hold_seen = hold_asks;
        hold_left = HOLD_LEN;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: ends a run in which nothing moves for too long
  // --------------------------------------------------------------------------
  int unsigned stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_MAX) begin
        $display("tb_rotary_encoder_with_button failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // request builders
  // --------------------------------------------------------------------------
  function automatic knob_req_t tick_req(logic a, logic b, logic btn);
    knob_req_t r;
    r.kind  = KIND_TICK;
    r.a     = a;
    r.b     = b;
    r.btn   = btn;
    r.value = VW'($urandom);
    r.lo    = VW'($urandom);
    r.hi    = VW'($urandom);
    return r;
  endfunction

  function automatic knob_req_t apply_req(logic [VW-1:0] v, logic [VW-1:0] lo,
                                          logic [VW-1:0] hi);
    knob_req_t r;
    r.kind  = KIND_APPLY;
    r.a     = 1'($urandom_range(0, 1));
    r.b     = 1'($urandom_range(0, 1));
    r.btn   = 1'($urandom_range(0, 1));
    r.value = v;
    r.lo    = lo;
    r.hi    = hi;
    return r;
  endfunction

  // button pin for the next tick: steady level with occasional bounce
  function automatic logic next_button();
    if ($urandom_range(0, 11) == 0) btn_level = !btn_level;
    return ($urandom_range(0, 9) == 0) ? !btn_level : btn_level;
  endfunction

  function automatic knob_req_t random_tick(logic a, logic b);
    return tick_req(a, b, next_button());
  endfunction

  // apply with values leaning on the wrap points and the field extremes
  function automatic knob_req_t random_apply();
    logic [VW-1:0] lo, hi, v, t;
    lo = VW'($urandom);
    hi = VW'($urandom);
    case ($urandom_range(0, 9))
      0: lo = '0;
      1: hi = '1;
      2: begin lo = '0; hi = '1; end
      3, 4: ;  // limits left as drawn, often reversed
      default: begin
        if (lo > hi) begin t = lo; lo = hi; hi = t; end
      end
    endcase
    case ($urandom_range(0, 6))
      0: v = lo;
      1: v = hi;
      2: v = '0;
      3: v = '1;
      4: v = lo + 1'b1;
      5: v = hi - 1'b1;
      default: v = VW'($urandom);
    endcase
    return apply_req(v, lo, hi);
  endfunction

  // queues one stretch of stimulus: mostly a full click gesture with random
  // content, sometimes a bare apply or plain noise
  task automatic queue_gesture();
    int unsigned roll;
    logic        right;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      right = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) stim_q.push_back(random_tick(1'b1, 1'b1));
      stim_q.push_back(random_tick(1'b0, 1'b0));
      repeat ($urandom_range(0, 2)) stim_q.push_back(random_tick(1'b0, 1'b0));
      if ($urandom_range(0, 3) == 0) stim_q.push_back(random_tick(1'b1, 1'b1));
      stim_q.push_back(random_tick(!right, right));
      // click is latched, pins here must be ignored
      repeat ($urandom_range(0, 2))
        stim_q.push_back(random_tick(1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1))));
      stim_q.push_back(random_apply());
    end else if (roll < 82) begin
      stim_q.push_back(random_apply());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) == 0) stim_q.push_back(random_apply());
        else stim_q.push_back(random_tick(1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1))));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // request driver: random idle, then hold the request until accepted
  // --------------------------------------------------------------------------
  task automatic send_req(knob_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= r.kind;
    pin_a_i       <= r.a;
    pin_b_i       <= r.b;
    button_pin_i  <= r.btn;
    edit_value_i  <= r.value;
    lower_limit_i <= r.lo;
    upper_limit_i <= r.hi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // stop offering, wait for every owed result, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // period register is only touched while the block is empty
  task automatic write_period(logic [PERIOD_W-1:0] p);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_period(p);
  endtask

  task automatic send_all();
    while (stim_q.size() != 0) send_req(stim_q.pop_front());
  endtask

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  // random phases: sample period and request count per phase
  int unsigned phase_period[9] = '{1, 3, 255, 2, 0, 7, 10, 255, 1};
  int unsigned phase_items[9]  = '{200, 200, 250, 200, 150, 200, 200, 250, 200};

  initial begin
    int unsigned sent;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening at the reset period of ten
    // apply with nothing latched passes the value through
    stim_q.push_back(apply_req(16'h1234, '0, '1));
    stim_q.push_back(tick_req(1'b1, 1'b1, 1'b0));
    stim_q.push_back(tick_req(1'b0, 1'b0, 1'b0));
    stim_q.push_back(tick_req(1'b1, 1'b1, 1'b1));
    stim_q.push_back(tick_req(1'b0, 1'b1, 1'b0));
    // right click latched, pins ignored until applied
    stim_q.push_back(tick_req(1'b1, 1'b0, 1'b1));
    stim_q.push_back(apply_req(16'h0005, 16'h0000, 16'h0010));
    // right at the upper limit wraps to the lower one
    stim_q.push_back(tick_req(1'b0, 1'b0, 1'b0));
    stim_q.push_back(tick_req(1'b0, 1'b1, 1'b0));
    stim_q.push_back(apply_req(16'hFFFF, 16'h0000, 16'hFFFF));
    // left step and left wrap at the lower limit
    stim_q.push_back(tick_req(1'b0, 1'b0, 1'b1));
    stim_q.push_back(tick_req(1'b1, 1'b0, 1'b1));
    stim_q.push_back(apply_req(16'h0007, 16'h0002, 16'h0009));
    stim_q.push_back(tick_req(1'b0, 1'b0, 1'b1));
    stim_q.push_back(tick_req(1'b1, 1'b0, 1'b0));
    stim_q.push_back(apply_req(16'h0000, 16'h0000, 16'hFFFF));
    // reversed limits, right then left
    stim_q.push_back(tick_req(1'b0, 1'b0, 1'b0));
    stim_q.push_back(tick_req(1'b0, 1'b1, 1'b0));
    stim_q.push_back(apply_req(16'h8000, 16'hFFFF, 16'h0000));
    stim_q.push_back(tick_req(1'b0, 1'b0, 1'b0));
    stim_q.push_back(tick_req(1'b1, 1'b0, 1'b0));
    stim_q.push_back(apply_req(16'h8000, 16'hFFFF, 16'h0000));
    send_all();

    // zero period fires a button event on every tick, four low ticks vote
    write_period('0);
    repeat (4) stim_q.push_back(tick_req(1'b1, 1'b1, 1'b0));
    send_all();

    // count up under the longest period, then drop the period below the count
    write_period(8'd255);
    repeat (3) stim_q.push_back(tick_req(1'b1, 1'b1, 1'b1));
    send_all();
    write_period(8'd2);
    stim_q.push_back(tick_req(1'b1, 1'b1, 1'b1));
    send_all();

    // random phases: sender lightly idle, then receiver lightly idle, then none
    for (int p = 0; p < 9; p++) begin
      write_period(PERIOD_W'(phase_period[p]));
      case (p / 3)
        0: begin send_idle_pct = 13; recv_stall_pct = 71; end
        1: begin send_idle_pct = 71; recv_stall_pct = 13; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // back-pressure stretch while requests keep coming
      if (p == 6) hold_asks++;
      sent = 0;
      while (sent < phase_items[p]) begin
        if (stim_q.size() == 0) queue_gesture();
        send_req(stim_q.pop_front());
        sent++;
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb_rotary_encoder_with_button passed");
    end else begin
      $display("tb_rotary_encoder_with_button failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/reb_pkg.sv
rtl/core/reb_turn_dec.sv
rtl/core/reb_value_edit.sv
rtl/core/reb_btn_vote.sv
rtl/core/rotary_encoder_with_button.sv
tb/sv/tb_rotary_encoder_with_button.sv
